@@ rtl/core/lprp_pkg.sv @@
// Shared constants, types and helper functions for the lidar packet return parser.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package lprp_pkg;

	localparam int BLOCKS       = 12;
	localparam int LASERS       = 16;
	localparam int BLOCK_BYTES  = 4 + 6 * LASERS;
	localparam int DATA_BYTES   = BLOCKS * BLOCK_BYTES;
	localparam int PACKET_BYTES = DATA_BYTES + 6;
	localparam int POS_W        = 11;
	localparam int POS_MAX      = (1 << POS_W) - 1;
	localparam int OFF_W        = $clog2(BLOCK_BYTES);
	localparam int BLK_W        = 4;
	localparam int CH_W         = $clog2(LASERS);
	localparam int RET_W        = $clog2(2 * LASERS);
	localparam int AZ_W         = 16;
	localparam int DIST_W       = 16;
	localparam int ENTRY_W      = DIST_W + 8;
	localparam int FULL_TURN    = 36000;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = QPTR_W + 1;

	localparam int OFF_AZ_LO    = 2;
	localparam int OFF_AZ_HI    = 3;
	localparam int OFF_RET      = 4;

	typedef enum logic [1:0] {
		CMD_POINT = 2'd0,
		CMD_DRAIN = 2'd1,
		CMD_ERR   = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic              err;
		logic [AZ_W-1:0]   az_base;
		logic [AZ_W-1:0]   az_prev;
		logic [AZ_W-1:0]   az_cur;
		logic [DIST_W-1:0] dist_raw;
		logic [7:0]        inten;
		logic [CH_W-1:0]   ch;
		logic [BLK_W-1:0]  blk;
	} cmd_t;

	function automatic logic [AZ_W-1:0] reduce_turn(input logic [AZ_W:0] a);
		logic [AZ_W:0] d;
		d = a - (AZ_W+1)'(FULL_TURN);
		return (a >= (AZ_W+1)'(FULL_TURN)) ? d[AZ_W-1:0] : a[AZ_W-1:0];
	endfunction

	function automatic logic signed [4:0] elevation(input logic [CH_W-1:0] ch);
		logic [4:0] e;
		e = ch[0] ? 5'(ch) : (5'(ch) - 5'd15);
		return signed'(e);
	endfunction

endpackage

@@ rtl/core/lprp_front.sv @@
// Front part: accepts packet bytes, tracks the position in the packet and issues commands.
// Holds the second-firing buffer and serves its read port. Depends on lprp_pkg.
module lprp_front import lprp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               end_of_packet,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               push,
	output cmd_t               push_cmd,
	input  logic               full,
	input  logic [CH_W-1:0]    rd_addr,
	output logic [ENTRY_W-1:0] rd_data_q
);

	logic [POS_W-1:0]   pos_q;
	logic [OFF_W-1:0]   off_q;
	logic [BLK_W-1:0]   blk_q;
	logic [RET_W-1:0]   ret_q;
	logic [1:0]         k_q;
	logic [7:0]         low_q;
	logic [DIST_W-1:0]  dist_q;
	logic [AZ_W-1:0]    azc_q;
	logic [AZ_W-1:0]    azp_q;
	logic               pending_q;
	logic [ENTRY_W-1:0] buf_q [LASERS];

	logic            acc;
	logic            in_data;
	logic            is_az;
	logic            is_ret;
	logic            is_int;
	logic            first_half;
	logic            last_ret;
	logic            last_blk;
	logic            len_err;
	logic            mid_drain;
	logic            end_drain;
	logic            have;
	logic [AZ_W-1:0] az_new;
	logic [CH_W-1:0] slot;

	assign in_ready   = !full;
	assign acc        = in_valid && !full;
	assign in_data    = pos_q < POS_W'(DATA_BYTES);
	assign is_az      = in_data && (off_q == OFF_W'(OFF_AZ_HI));
	assign is_ret     = in_data && (off_q >= OFF_W'(OFF_RET));
	assign is_int     = is_ret && (k_q == 2'd2);
	assign first_half = ret_q < RET_W'(LASERS);
	assign last_ret   = ret_q == RET_W'(2 * LASERS - 1);
	assign last_blk   = blk_q == BLK_W'(BLOCKS - 1);
	assign len_err    = end_of_packet && (pos_q != POS_W'(PACKET_BYTES - 1));
	assign az_new     = reduce_turn({1'b0, data_byte, low_q});
	assign slot       = ret_q[CH_W-1:0];
	assign mid_drain  = is_az && pending_q && (blk_q != '0);
	assign end_drain  = is_int && !first_half && last_ret && last_blk;

	always_comb begin
		push_cmd = '0;
		push_cmd.op = CMD_ERR;
		have = 1'b0;
		if (mid_drain) begin
			have = 1'b1;
			push_cmd.op = CMD_DRAIN;
			push_cmd.az_base = azc_q;
			push_cmd.az_prev = azc_q;
			push_cmd.az_cur = az_new;
			push_cmd.blk = blk_q - BLK_W'(1);
		end else if (is_int && first_half) begin
			have = 1'b1;
			push_cmd.op = CMD_POINT;
			push_cmd.az_base = azc_q;
			push_cmd.dist_raw = dist_q;
			push_cmd.inten = data_byte;
			push_cmd.ch = slot;
			push_cmd.blk = blk_q;
		end else if (end_drain) begin
			have = 1'b1;
			push_cmd.op = CMD_DRAIN;
			push_cmd.az_base = azc_q;
			push_cmd.az_prev = azp_q;
			push_cmd.az_cur = azc_q;
			push_cmd.blk = blk_q;
		end
		push_cmd.err = have && len_err;
		push = acc && (have || len_err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			off_q <= '0;
			blk_q <= '0;
			ret_q <= '0;
			k_q <= '0;
			pending_q <= 1'b0;
		end else if (acc) begin
			if (end_of_packet) begin
				pos_q <= '0;
				off_q <= '0;
				blk_q <= '0;
				ret_q <= '0;
				k_q <= '0;
				pending_q <= 1'b0;
			end else begin
				if (pos_q != POS_W'(POS_MAX)) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (in_data) begin
					if (off_q == OFF_W'(BLOCK_BYTES - 1)) begin
						off_q <= '0;
						blk_q <= blk_q + BLK_W'(1);
						ret_q <= '0;
						k_q <= '0;
					end else begin
						off_q <= off_q + OFF_W'(1);
						if (is_ret) begin
							if (k_q == 2'd2) begin
								k_q <= '0;
								ret_q <= ret_q + RET_W'(1);
							end else begin
								k_q <= k_q + 2'd1;
							end
						end
					end
				end
				if (mid_drain) begin
					pending_q <= 1'b0;
				end else if (is_int && !first_half && last_ret && !last_blk) begin
					pending_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if ((in_data && off_q == OFF_W'(OFF_AZ_LO)) || (is_ret && k_q == 2'd0)) begin
				low_q <= data_byte;
			end
			if (is_ret && k_q == 2'd1) begin
				dist_q <= {data_byte, low_q};
			end
			if (is_az) begin
				azp_q <= azc_q;
				azc_q <= az_new;
			end
			if (is_int && !first_half) begin
				buf_q[slot] <= {dist_q, data_byte};
			end
		end
		rd_data_q <= buf_q[rd_addr];
	end

endmodule

@@ rtl/core/lprp_queue.sv @@
// Short command queue between the front and back parts of the packet parser.
// Head entry is visible without a pop. Depends on lprp_pkg.
module lprp_queue import lprp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QDEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("Command pushed into a full queue.");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("Command popped from an empty queue.");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("Queue count did not follow a push.");

endmodule

@@ rtl/core/lprp_back.sv @@
// Back part: expands queued commands into result items held in an output register.
// Computes the second-firing azimuth and walks the buffer. Depends on lprp_pkg.
module lprp_back import lprp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                head,
	input  logic                empty,
	output logic                pop,
	output logic [CH_W-1:0]     rd_addr,
	input  logic [ENTRY_W-1:0]  rd_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [AZ_W-1:0]     azimuth_centideg,
	output logic [DIST_W:0]     distance_mm,
	output logic [7:0]          intensity,
	output logic [CH_W-1:0]     laser_channel,
	output logic signed [4:0]   elevation_deg,
	output logic [BLK_W-1:0]    block_number,
	output logic                firing_half,
	output logic                last_in_run
);

	typedef enum logic [3:0] {
		ST_HEAD  = 4'b0001,
		ST_SUM   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_ERR   = 4'b1000
	} st_t;

	st_t               state_q;
	st_t               state_d;
	logic [CH_W-1:0]   idx_q;
	logic [CH_W-1:0]   idx_d;
	logic [AZ_W-2:0]   half_q;
	logic [AZ_W-1:0]   azd_q;
	logic              valid_q;
	logic              kind_q;
	logic [AZ_W-1:0]   az_q;
	logic [DIST_W:0]   dist_q;
	logic [7:0]        int_q;
	logic [CH_W-1:0]   ch_q;
	logic signed [4:0] elev_q;
	logic [BLK_W-1:0]  blk_q;
	logic              half_sel_q;
	logic              last_q;

	logic              slot_free;
	logic              load;
	logic              l_kind;
	logic [AZ_W-1:0]   l_az;
	logic [DIST_W:0]   l_dist;
	logic [7:0]        l_int;
	logic [CH_W-1:0]   l_ch;
	logic [BLK_W-1:0]  l_blk;
	logic              l_half;
	logic              l_last;
	logic [AZ_W:0]     diff;
	logic [AZ_W:0]     step;

	assign slot_free = !valid_q || out_ready;
	assign diff = {1'b0, head.az_cur} - {1'b0, head.az_prev};
	assign step = diff[AZ_W] ? (diff + (AZ_W+1)'(FULL_TURN)) : diff;
	assign rd_addr = idx_d;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pop = 1'b0;
		load = 1'b0;
		l_kind = 1'b0;
		l_az = '0;
		l_dist = '0;
		l_int = '0;
		l_ch = '0;
		l_blk = '0;
		l_half = 1'b0;
		l_last = 1'b0;
		case (state_q)
			ST_HEAD: begin
				if (!empty) begin
					case (head.op)
						CMD_POINT: begin
							if (slot_free) begin
								load = 1'b1;
								l_az = head.az_base;
								l_dist = {head.dist_raw, 1'b0};
								l_int = head.inten;
								l_ch = head.ch;
								l_blk = head.blk;
								l_last = !head.err;
								if (head.err) begin
									state_d = ST_ERR;
								end else begin
									pop = 1'b1;
								end
							end
						end
						CMD_DRAIN: begin
							state_d = ST_SUM;
						end
						default: begin
							if (slot_free) begin
								load = 1'b1;
								l_kind = 1'b1;
								l_last = 1'b1;
								pop = 1'b1;
							end
						end
					endcase
				end
			end
			ST_SUM: begin
				idx_d = '0;
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (slot_free) begin
					load = 1'b1;
					l_az = azd_q;
					l_dist = {rd_data[ENTRY_W-1:8], 1'b0};
					l_int = rd_data[7:0];
					l_ch = idx_q;
					l_blk = head.blk;
					l_half = 1'b1;
					l_last = (idx_q == CH_W'(LASERS - 1)) && !head.err;
					idx_d = idx_q + CH_W'(1);
					if (idx_q == CH_W'(LASERS - 1)) begin
						if (head.err) begin
							state_d = ST_ERR;
						end else begin
							pop = 1'b1;
							state_d = ST_HEAD;
						end
					end
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					load = 1'b1;
					l_kind = 1'b1;
					l_last = 1'b1;
					pop = 1'b1;
					state_d = ST_HEAD;
				end
			end
			default: begin
				state_d = ST_HEAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEAD;
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HEAD) begin
			half_q <= step[AZ_W-1:1];
		end
		if (state_q == ST_SUM) begin
			azd_q <= reduce_turn({1'b0, head.az_base} + (AZ_W+1)'(half_q));
		end
		if (load) begin
			kind_q <= l_kind;
			az_q <= l_az;
			dist_q <= l_dist;
			int_q <= l_int;
			ch_q <= l_ch;
			elev_q <= l_kind ? 5'sd0 : elevation(l_ch);
			blk_q <= l_blk;
			half_sel_q <= l_half;
			last_q <= l_last;
		end
	end

	assign out_valid        = valid_q;
	assign kind             = kind_q;
	assign azimuth_centideg = az_q;
	assign distance_mm      = dist_q;
	assign intensity        = int_q;
	assign laser_channel    = ch_q;
	assign elevation_deg    = elev_q;
	assign block_number     = blk_q;
	assign firing_half      = half_sel_q;
	assign last_in_run      = last_q;

	a_sum_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |=> state_q == ST_DRAIN)
		else $error("Azimuth sum step not followed by the drain.");
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && state_q == ST_DRAIN) |-> (idx_q == CH_W'(LASERS - 1)))
		else $error("Drain command released before its last item.");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> $stable(az_q) && $stable(last_q))
		else $error("Output register changed while stalled.");

endmodule

@@ rtl/core/lidar_packet_return_parser.sv @@
// Lidar packet return parser: one payload byte per item in; points and length errors out.
// A first-firing point is queued with its intensity byte; a second firing is drained from the
// buffer via ST_SUM and ST_DRAIN as 16 items, one per cycle unless the output stalls.
// Throughput: one byte per cycle unless the full 4-entry command queue stalls the input.
// Reset (arst_n, asynchronous, active low) clears position, pending flag, queue and output.
// Depends on lprp_pkg, lprp_front, lprp_queue and lprp_back.
module lidar_packet_return_parser import lprp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                end_of_packet,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [AZ_W-1:0]     azimuth_centideg,
	output logic [DIST_W:0]     distance_mm,
	output logic [7:0]          intensity,
	output logic [CH_W-1:0]     laser_channel,
	output logic signed [4:0]   elevation_deg,
	output logic [BLK_W-1:0]    block_number,
	output logic                firing_half,
	output logic                last_in_run
);

	logic               push;
	cmd_t               push_cmd;
	logic               pop;
	cmd_t               head;
	logic               full;
	logic               empty;
	logic [CH_W-1:0]    rd_addr;
	logic [ENTRY_W-1:0] rd_data;

	lprp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.push          (push),
		.push_cmd      (push_cmd),
		.full          (full),
		.rd_addr       (rd_addr),
		.rd_data_q     (rd_data)
	);

	lprp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	lprp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.empty            (empty),
		.pop              (pop),
		.rd_addr          (rd_addr),
		.rd_data          (rd_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.azimuth_centideg (azimuth_centideg),
		.distance_mm      (distance_mm),
		.intensity        (intensity),
		.laser_channel    (laser_channel),
		.elevation_deg    (elevation_deg),
		.block_number     (block_number),
		.firing_half      (firing_half),
		.last_in_run      (last_in_run)
	);

endmodule

@@ test/tb_lidar_packet_return_parser.sv @@
`timescale 1ns / 1ps
// Testbench for lidar_packet_return_parser: directed byte table, then random packets, idling or not.
// Points and length errors, predicted per accepted byte or typed in the table, are checked in order.
// Depends on lprp_pkg and the parser RTL only.
module tb_lidar_packet_return_parser;
	import lprp_pkg::*;

	localparam logic KIND_POINT      = 1'b0;
	localparam logic KIND_LENGTH_ERR = 1'b1;
	localparam int   AZ_STEADY       = 0;
	localparam int   AZ_RAW          = 1;
	localparam int   AZ_WRAP         = 2;
	localparam int   CYCLE_LIMIT     = 600000;
	localparam int   DRAIN_TAIL      = 64;
	localparam int   DIRECTED_COUNT  = 26;
	localparam int   LONG_PACKET     = BLOCK_BYTES + 12;

	typedef struct packed {
		logic                 kind;
		logic [AZ_W-1:0]      azimuth;
		logic [DIST_W:0]      distance;
		logic [7:0]           intensity;
		logic [CH_W-1:0]      channel;
		logic signed [4:0]    elevation;
		logic [BLK_W-1:0]     block;
		logic                 half;
		logic                 last_in_run;
	} point_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eop;
		logic       typed;
		point_t     want;
	} stim_row_t;

	localparam point_t LENGTH_ERR = '{KIND_LENGTH_ERR, 16'd0, 17'd0, 8'd0, 4'd0, 5'sd0, 4'd0,
		1'b0, 1'b1};
	localparam point_t NO_RESULT  = '0;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = '0;
	logic                end_of_packet = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                kind;
	logic [AZ_W-1:0]     azimuth_centideg;
	logic [DIST_W:0]     distance_mm;
	logic [7:0]          intensity;
	logic [CH_W-1:0]     laser_channel;
	logic signed [4:0]   elevation_deg;
	logic [BLK_W-1:0]    block_number;
	logic                firing_half;
	logic                last_in_run;

	int                  send_idle_pct = 38;
	int                  recv_idle_pct = 50;
	int                  mismatch_count = 0;
	int                  cycle_count = 0;
	point_t              awaited_points[$];
	point_t              step_points[$];
	point_t              head_point;

	int unsigned         byte_pos = 0;
	logic [7:0]          low_byte = '0;
	logic [15:0]         dist_latch = '0;
	int unsigned         az_now = 0;
	int unsigned         az_last = 0;
	logic [23:0]         second_firing [LASERS];
	logic                firing_pending = 1'b0;

	stim_row_t directed_rows [DIRECTED_COUNT] = '{
		'{8'h5A, 1'b1, 1'b1, LENGTH_ERR},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hEE, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b1, '{KIND_POINT, 16'd29535, 17'd131070, 8'hFF, 4'd0, -5'sd15,
			4'd0, 1'b0, 1'b1}},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b1, '{KIND_POINT, 16'd29535, 17'd0, 8'h00, 4'd1, 5'sd1,
			4'd0, 1'b0, 1'b1}},
		'{8'h77, 1'b1, 1'b1, LENGTH_ERR},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hEE, 1'b0, 1'b0, NO_RESULT},
		'{8'h9F, 1'b0, 1'b0, NO_RESULT},
		'{8'h8C, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h7F, 1'b1, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hEE, 1'b0, 1'b0, NO_RESULT},
		'{8'hA0, 1'b0, 1'b0, NO_RESULT},
		'{8'h8C, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b1, 1'b0, NO_RESULT}
	};

	lidar_packet_return_parser i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.end_of_packet    (end_of_packet),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.azimuth_centideg (azimuth_centideg),
		.distance_mm      (distance_mm),
		.intensity        (intensity),
		.laser_channel    (laser_channel),
		.elevation_deg    (elevation_deg),
		.block_number     (block_number),
		.firing_half      (firing_half),
		.last_in_run      (last_in_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned fold_turn(input int unsigned a);
		return (a >= FULL_TURN) ? a - FULL_TURN : a;
	endfunction

	function automatic int unsigned half_turn_step(input int unsigned prev, input int unsigned cur);
		return ((cur >= prev) ? cur - prev : cur + FULL_TURN - prev) / 2;
	endfunction

	function automatic point_t return_point(input int unsigned az, input logic [15:0] dist_raw,
		input logic [7:0] inten, input int unsigned ch, input int unsigned blk, input logic half);
		point_t p;
		int e;
		e = (ch % 2) ? int'(ch) : int'(ch) - 15;
		p = '0;
		p.kind = KIND_POINT;
		p.azimuth = AZ_W'(az);
		p.distance = {dist_raw, 1'b0};
		p.intensity = inten;
		p.channel = CH_W'(ch);
		p.elevation = 5'(e);
		p.block = BLK_W'(blk);
		p.half = half;
		return p;
	endfunction

	task automatic flush_second_firing(input int unsigned az, input int unsigned blk);
		for (int unsigned i = 0; i < LASERS; i++) begin
			step_points.push_back(return_point(az, second_firing[i][23:8], second_firing[i][7:0],
				i, blk, 1'b1));
		end
		firing_pending = 1'b0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eop);
		int unsigned pos;
		int unsigned blk;
		int unsigned off;
		int unsigned ret;
		int unsigned phase3;
		step_points = {};
		pos = byte_pos;
		if (pos < DATA_BYTES) begin
			blk = pos / BLOCK_BYTES;
			off = pos % BLOCK_BYTES;
			if (off == OFF_AZ_LO) begin
				low_byte = b;
			end else if (off == OFF_AZ_HI) begin
				az_last = az_now;
				az_now = fold_turn({b, low_byte});
				if (firing_pending && blk > 0) begin
					flush_second_firing(fold_turn(az_last + half_turn_step(az_last, az_now)),
						blk - 1);
				end
			end else if (off >= OFF_RET) begin
				ret = (off - OFF_RET) / 3;
				phase3 = (off - OFF_RET) % 3;
				if (phase3 == 0) begin
					low_byte = b;
				end else if (phase3 == 1) begin
					dist_latch = {b, low_byte};
				end else if (ret < LASERS) begin
					step_points.push_back(return_point(az_now, dist_latch, b, ret, blk, 1'b0));
				end else begin
					second_firing[ret - LASERS] = {dist_latch, b};
					if (ret == 2 * LASERS - 1) begin
						if (blk == BLOCKS - 1) begin
							flush_second_firing(fold_turn(az_now + half_turn_step(az_last, az_now)),
								blk);
						end else begin
							firing_pending = 1'b1;
						end
					end
				end
			end
		end
		if (eop) begin
			if (pos + 1 != PACKET_BYTES) begin
				step_points.push_back(LENGTH_ERR);
			end
			byte_pos = 0;
			firing_pending = 1'b0;
		end else if (pos < POS_MAX) begin
			byte_pos = pos + 1;
		end
		if (step_points.size() > 0) begin
			step_points[step_points.size() - 1].last_in_run = 1'b1;
		end
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic eop, input logic typed,
		input point_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_packet <= eop;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		decode_byte(b, eop);
		if (typed) begin
			awaited_points.push_back(want);
		end else begin
			foreach (step_points[i]) begin
				awaited_points.push_back(step_points[i]);
			end
		end
	endtask

	task automatic send_packet(input int unsigned len, input int az_mode, input bit noise);
		int unsigned az_raw;
		int unsigned off;
		logic [7:0] b;
		az_raw = (az_mode == AZ_WRAP) ? FULL_TURN - 1 - $urandom_range(0, 200)
			: $urandom_range(0, FULL_TURN - 1);
		for (int unsigned p = 0; p < len; p++) begin
			off = p % BLOCK_BYTES;
			b = 8'($urandom);
			if (!noise && p < DATA_BYTES) begin
				if (off == OFF_AZ_LO) begin
					if (az_mode == AZ_RAW) begin
						az_raw = $urandom_range(0, 65535);
					end else if (p >= BLOCK_BYTES) begin
						az_raw = fold_turn(az_raw + ((az_mode == AZ_WRAP) ? $urandom_range(10, 60)
							: $urandom_range(0, 80)));
					end
					b = az_raw[7:0];
				end else if (off == OFF_AZ_HI) begin
					b = az_raw[15:8];
				end
			end
			feed_byte(b, p == len - 1, 1'b0, NO_RESULT);
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (awaited_points.size() == 0) begin
				$error("item arrived with none awaited: kind %0d, azimuth %0d", kind,
					azimuth_centideg);
				mismatch_count++;
			end else begin
				head_point = awaited_points.pop_front();
				check_field("kind", head_point.kind, kind);
				check_field("azimuth_centideg", head_point.azimuth, azimuth_centideg);
				check_field("distance_mm", head_point.distance, distance_mm);
				check_field("intensity", head_point.intensity, intensity);
				check_field("laser_channel", head_point.channel, laser_channel);
				check_field("elevation_deg", head_point.elevation, elevation_deg);
				check_field("block_number", head_point.block, block_number);
				check_field("firing_half", head_point.half, firing_half);
				check_field("last_in_run", head_point.last_in_run, last_in_run);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			feed_byte(directed_rows[i].data, directed_rows[i].eop, directed_rows[i].typed,
				directed_rows[i].want);
		end
		for (int round = 0; round < 3; round++) begin
			if (round == 1) begin
				send_idle_pct = 50;
				recv_idle_pct = 38;
			end else if (round == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (round == 2) begin
				send_packet(LONG_PACKET, AZ_WRAP, 1'b0);
			end else begin
				send_packet($urandom_range(12, 20), $urandom_range(AZ_STEADY, AZ_WRAP),
					1'($urandom_range(0, 1)));
			end
		end
		in_valid <= 1'b0;
		while (awaited_points.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
